>>> rtl/abdl_pkg.sv
// Shared types and constants for the active bitmap delta lister.
// Used by the channel interfaces and by every module under rtl/.
package abdl_pkg;

    // Sizing
    localparam int MAX_SENONES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int QUEUE_DEPTH = 2;

    // Fixed field widths
    localparam int IN_W    = 32;
    localparam int CFG_W   = 13;
    localparam int CNT_W   = 13;
    localparam int DELTA_W = 8;

    // Derived widths
    localparam int MAX_WORDS = (MAX_SENONES + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W     = $clog2(MAX_SENONES);
    localparam int EFF_W     = $clog2(MAX_SENONES + 1);
    localparam int WP_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int POS_W     = $clog2(WORD_BITS);
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Constants
    localparam logic [CFG_W-1:0]   TOTAL_RESET = CFG_W'(MAX_SENONES);
    localparam logic [IDX_W-1:0]   GAP_LIMIT   = IDX_W'(255);
    localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};

    // Register indexes
    localparam logic CFG_TOTAL_SENONES = 1'b0;
    localparam logic CFG_ALL_ACTIVE    = 1'b1;

    // Result kinds
    localparam logic KIND_DELTA = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // One classified word handed from front to back
    typedef struct packed {
        logic [WORD_BITS-1:0] word;   // masked flags, zero in all-active mode
        logic [IDX_W-1:0]     base;   // index of bit 0
        logic                 last;   // word closes the scan
        logic                 all;    // all-active mode seen on this word
        logic [EFF_W-1:0]     eff;    // clamped senone count
        logic                 start;  // first word of a scan
    } t_work;

    // Queue status seen by both sides
    typedef struct packed {
        logic can_push;
        logic has_item;
    } t_q_status;

endpackage

>>> rtl/abdl_if.sv
// Valid/ready channel interfaces: input words, result entries, config writes.
// Depends on abdl_pkg for field widths.
interface abdl_in_if;
    logic                          valid;
    logic                          ready;
    logic [abdl_pkg::IN_W-1:0]     flag_word;
    logic                          scan_start;
    modport source (output valid, flag_word, scan_start, input ready);
    modport sink   (input valid, flag_word, scan_start, output ready);
endinterface

interface abdl_out_if;
    logic                          valid;
    logic                          ready;
    logic                          entry_kind;
    logic [abdl_pkg::DELTA_W-1:0]  delta;
    logic [abdl_pkg::CNT_W-1:0]    list_length;
    logic                          run_last;
    modport source (output valid, entry_kind, delta, list_length, run_last, input ready);
    modport sink   (input valid, entry_kind, delta, list_length, run_last, output ready);
endinterface

interface abdl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic                          index;
    logic [abdl_pkg::CFG_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/abdl_front.sv
// Front end: accepts bitmap words, tracks scan position, masks and classifies.
// Depends on abdl_pkg and abdl_in_if.
module abdl_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    abdl_in_if.sink                     i_in,
    input  logic [abdl_pkg::CFG_W-1:0]  i_total_senones,
    input  logic                        i_all_active,
    input  abdl_pkg::t_q_status         i_qstat,
    output logic                        o_push,
    output abdl_pkg::t_work             o_work
);

    logic [abdl_pkg::WP_W-1:0]   r_wp, n_wp;
    logic                        r_fin, n_fin;
    logic [abdl_pkg::WP_W-1:0]   w_wp;
    logic                        w_fin;
    logic [abdl_pkg::EFF_W-1:0]  w_eff;
    logic [abdl_pkg::EFF_W:0]    w_base;
    logic [abdl_pkg::EFF_W:0]    w_next_base;
    logic                        w_last;
    logic [abdl_pkg::WORD_BITS-1:0] w_mask;
    logic                        w_accept;

    assign i_in.ready = i_qstat.can_push;
    assign w_accept   = i_in.valid & i_qstat.can_push;

    // Scan start clears position before the word is judged
    assign w_wp  = i_in.scan_start ? '0 : r_wp;
    assign w_fin = i_in.scan_start ? 1'b0 : r_fin;

    // Clamp count to 1..MAX_SENONES
    always_comb begin
        if (i_total_senones == '0) begin
            w_eff = abdl_pkg::EFF_W'(1);
        end else if (i_total_senones > abdl_pkg::CFG_W'(abdl_pkg::MAX_SENONES)) begin
            w_eff = abdl_pkg::EFF_W'(abdl_pkg::MAX_SENONES);
        end else begin
            w_eff = abdl_pkg::EFF_W'(i_total_senones);
        end
    end

    assign w_base      = (abdl_pkg::EFF_W+1)'(w_wp) * (abdl_pkg::EFF_W+1)'(abdl_pkg::WORD_BITS);
    assign w_next_base = w_base + (abdl_pkg::EFF_W+1)'(abdl_pkg::WORD_BITS);
    assign w_last      = w_next_base >= {1'b0, w_eff};

    // Keep only positions below the count
    always_comb begin
        for (int b = 0; b < abdl_pkg::WORD_BITS; b++) begin
            w_mask[b] = (w_base + (abdl_pkg::EFF_W+1)'(b)) < {1'b0, w_eff};
        end
    end

    always_comb begin
        o_work.word  = i_all_active ? '0 : (i_in.flag_word[abdl_pkg::WORD_BITS-1:0] & w_mask);
        o_work.base  = abdl_pkg::IDX_W'(w_base);
        o_work.last  = w_last;
        o_work.all   = i_all_active;
        o_work.eff   = w_eff;
        o_work.start = i_in.scan_start;
    end

    // Words after the end of a scan are dropped
    assign o_push = w_accept & ~w_fin;

    always_comb begin
        n_wp  = r_wp;
        n_fin = r_fin;
        if (w_accept) begin
            n_wp  = w_wp;
            n_fin = w_fin;
            if (!w_fin) begin
                if (w_last) begin
                    n_fin = 1'b1;
                end else begin
                    n_wp = w_wp + abdl_pkg::WP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_fin <= 1'b0;
        end else begin
            r_wp  <= n_wp;
            r_fin <= n_fin;
        end
    end

endmodule

>>> rtl/abdl_queue.sv
// Short FIFO of classified words between front and back.
// Depends on abdl_pkg.
module abdl_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  abdl_pkg::t_work      i_work,
    input  logic                 i_pop,
    output abdl_pkg::t_work      o_head,
    output abdl_pkg::t_q_status  o_status
);

    abdl_pkg::t_work               r_mem [abdl_pkg::QUEUE_DEPTH];
    logic [abdl_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [abdl_pkg::QCNT_W-1:0]   r_cnt;
    logic                          w_push, w_pop;

    assign o_status.can_push = r_cnt != abdl_pkg::QCNT_W'(abdl_pkg::QUEUE_DEPTH);
    assign o_status.has_item = r_cnt != '0;
    assign w_push = i_push & o_status.can_push;
    assign w_pop  = i_pop & o_status.has_item;
    assign o_head = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == abdl_pkg::QPTR_W'(abdl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == abdl_pkg::QPTR_W'(abdl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + abdl_pkg::QCNT_W'(w_push) - abdl_pkg::QCNT_W'(w_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

>>> rtl/abdl_back.sv
// Back end: walks set bits of a queued word, emits deltas, bridges and the close.
// Depends on abdl_pkg and abdl_out_if.
module abdl_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  abdl_pkg::t_work      i_head,
    input  abdl_pkg::t_q_status  i_qstat,
    output logic                 o_pop,
    abdl_out_if.source           o_out
);

    typedef enum logic [1:0] {
        BK_LOAD = 2'b01,
        BK_RUN  = 2'b10
    } t_back_state;

    t_back_state                     r_state, n_state;
    logic [abdl_pkg::WORD_BITS-1:0]  r_word, n_word;
    logic [abdl_pkg::IDX_W-1:0]      r_base, n_base;
    logic                            r_last, n_last;
    logic                            r_all, n_all;
    logic [abdl_pkg::EFF_W-1:0]      r_eff, n_eff;
    logic [abdl_pkg::IDX_W-1:0]      r_prev, n_prev;
    logic [abdl_pkg::CNT_W-1:0]      r_count, n_count;
    logic [abdl_pkg::IDX_W-1:0]      r_pend, n_pend;
    logic                            r_pend_v, n_pend_v;
    logic                            r_out_valid, n_out_valid;
    logic                            r_kind, n_kind;
    logic [abdl_pkg::DELTA_W-1:0]    r_delta, n_delta;
    logic [abdl_pkg::CNT_W-1:0]      r_len, n_len;
    logic                            r_run_last, n_run_last;

    logic                            w_adv;
    logic [abdl_pkg::POS_W-1:0]      w_pos;
    logic [abdl_pkg::IDX_W-1:0]      w_idx;
    logic [abdl_pkg::IDX_W-1:0]      w_gap;
    logic [abdl_pkg::IDX_W-1:0]      w_d;
    logic                            w_bridge;
    logic [abdl_pkg::WORD_BITS-1:0]  w_word_cl;
    logic [abdl_pkg::CNT_W-1:0]      w_count_inc;

    // Output register can take a new entry
    assign w_adv = ~r_out_valid | o_out.ready;

    // Lowest set bit
    always_comb begin
        w_pos = '0;
        for (int b = abdl_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (r_word[b]) begin
                w_pos = abdl_pkg::POS_W'(b);
            end
        end
    end

    assign w_idx       = r_base + abdl_pkg::IDX_W'(w_pos);
    assign w_gap       = (w_idx >= r_prev) ? (w_idx - r_prev) : '0;
    assign w_d         = r_pend_v ? r_pend : w_gap;
    assign w_bridge    = w_d > abdl_pkg::GAP_LIMIT;
    assign w_word_cl   = r_word & (r_word - abdl_pkg::WORD_BITS'(1));
    assign w_count_inc = (r_count != abdl_pkg::COUNT_MAX) ?
                         r_count + abdl_pkg::CNT_W'(1) : r_count;

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_base      = r_base;
        n_last      = r_last;
        n_all       = r_all;
        n_eff       = r_eff;
        n_prev      = r_prev;
        n_count     = r_count;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_out_valid = w_adv ? 1'b0 : r_out_valid;
        n_kind      = r_kind;
        n_delta     = r_delta;
        n_len       = r_len;
        n_run_last  = r_run_last;
        o_pop       = 1'b0;

        unique case (r_state)
            // Take the next word; scan start resets list state
            BK_LOAD: begin
                if (i_qstat.has_item) begin
                    o_pop    = 1'b1;
                    n_word   = i_head.word;
                    n_base   = i_head.base;
                    n_last   = i_head.last;
                    n_all    = i_head.all;
                    n_eff    = i_head.eff;
                    n_pend_v = 1'b0;
                    if (i_head.start) begin
                        n_prev  = '0;
                        n_count = '0;
                    end
                    n_state = BK_RUN;
                end
            end
            // One entry per cycle while the output register is free
            BK_RUN: begin
                if (w_adv) begin
                    if (r_word != '0) begin
                        n_out_valid = 1'b1;
                        n_kind      = abdl_pkg::KIND_DELTA;
                        n_len       = '0;
                        n_count     = w_count_inc;
                        if (w_bridge) begin
                            n_delta    = abdl_pkg::DELTA_W'(abdl_pkg::GAP_LIMIT);
                            n_run_last = 1'b0;
                            n_pend     = w_d - abdl_pkg::GAP_LIMIT;
                            n_pend_v   = 1'b1;
                        end else begin
                            n_delta    = abdl_pkg::DELTA_W'(w_d);
                            n_run_last = (w_word_cl == '0) & ~r_last;
                            n_word     = w_word_cl;
                            n_prev     = w_idx;
                            n_pend_v   = 1'b0;
                            if ((w_word_cl == '0) && !r_last) begin
                                n_state = BK_LOAD;
                            end
                        end
                    end else if (r_last) begin
                        n_out_valid = 1'b1;
                        n_kind      = abdl_pkg::KIND_END;
                        n_delta     = '0;
                        n_len       = r_all ? abdl_pkg::CNT_W'(r_eff) : r_count;
                        n_run_last  = 1'b1;
                        n_state     = BK_LOAD;
                    end else begin
                        n_state = BK_LOAD;
                    end
                end
            end
            default: begin
                n_state = BK_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_LOAD;
            r_prev      <= '0;
            r_count     <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_word      <= '0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_count     <= n_count;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
            r_word      <= n_word;
            r_last      <= n_last;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_all      <= n_all;
        r_eff      <= n_eff;
        r_pend     <= n_pend;
        r_kind     <= n_kind;
        r_delta    <= n_delta;
        r_len      <= n_len;
        r_run_last <= n_run_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.entry_kind  = r_kind;
    assign o_out.delta       = r_delta;
    assign o_out.list_length = r_len;
    assign o_out.run_last    = r_run_last;

endmodule

>>> rtl/active_bitmap_delta_lister.sv
// Active bitmap delta lister: bitmap words in, delta list entries out.
// A word's first result is presented after it passes the queue, the back end's
// load state and its single output register. Per word the back end loads once,
// then emits one entry per delta, bridge or close while the output register is
// free, and later words wait in the queue. Reset (synchronous, active low)
// clears scan state and queue and sets total_senones to 4096, all_active to 0.
module active_bitmap_delta_lister (
    input  logic          i_clk,
    input  logic          i_rst_n,
    abdl_in_if.sink       i_in,
    abdl_out_if.source    o_out,
    abdl_cfg_if.sink      i_cfg
);

    logic [abdl_pkg::CFG_W-1:0]  r_total_senones;
    logic                        r_all_active;
    logic                        w_push;
    logic                        w_pop;
    abdl_pkg::t_work             w_work;
    abdl_pkg::t_work             w_head;
    abdl_pkg::t_q_status         w_qstat;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_senones <= abdl_pkg::TOTAL_RESET;
            r_all_active    <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                abdl_pkg::CFG_TOTAL_SENONES: r_total_senones <= i_cfg.data;
                abdl_pkg::CFG_ALL_ACTIVE:    r_all_active    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    abdl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_total_senones (r_total_senones),
        .i_all_active    (r_all_active),
        .i_qstat         (w_qstat),
        .o_push          (w_push),
        .o_work          (w_work)
    );

    abdl_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_work   (w_work),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qstat)
    );

    abdl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // A word enters the queue only on an accepted request with room left
    a_push_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (i_in.valid && i_in.ready && w_qstat.can_push))
        else $error("queue push without accepted request or room");

    // The back end pops only what is there
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qstat.has_item)
        else $error("queue pop while empty");

    // A closing entry ends its word's results and carries no delta
    a_close_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.entry_kind == abdl_pkg::KIND_END)
            |-> (o_out.run_last && o_out.delta == '0))
        else $error("malformed closing entry");

    // A delta entry carries no length
    a_delta_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.entry_kind == abdl_pkg::KIND_DELTA)
            |-> (o_out.list_length == '0))
        else $error("delta entry with nonzero length");

endmodule
